// ===== design/ddr_pkg.sv =====
// ddr_pkg: shared types, constants and register indexes of the decimal digit redraw block
`timescale 1ns / 1ps

package ddr_pkg;

  // value field width and digit split limits
  localparam int unsigned ValueBits = 8;
  localparam int unsigned NumSlots  = 3;
  localparam int unsigned NumCmds   = 2 * NumSlots;
  localparam int unsigned Radix     = 10;
  localparam int unsigned SatBits   = 10;
  localparam logic [SatBits-1:0] SatMax = SatBits'(Radix * Radix * Radix - 1);

  // reciprocal constants, exact for every value up to SatMax
  localparam int unsigned RecipTen       = 205;
  localparam int unsigned RecipTenShift  = 11;
  localparam int unsigned RecipHund      = 41;
  localparam int unsigned RecipHundShift = 12;

  // configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegCenterX      = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCenterY      = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegDigitWidth   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegDigitHeight  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDigitSpacing = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegGlyphOffset  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegEraseColor   = 3'd6;

  // transaction modes
  localparam logic ModeUpdate = 1'b0;
  localparam logic ModeHide   = 1'b1;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] count_t;
  typedef logic [2:0] cmd_idx_t;

  typedef digit_t [NumSlots-1:0] digit_list_t;

  typedef struct packed {
    logic   erase;
    count_t slot;
    count_t n;
    digit_t digit;
  } cmd_t;

  typedef cmd_t [NumCmds-1:0] cmd_list_t;

  typedef struct packed {
    cmd_list_t   cmds;
    cmd_idx_t    cnt;
    count_t      count;
    digit_list_t digits;
  } plan_t;

  typedef struct packed {
    logic                 mode;
    logic [ValueBits-1:0] value;
    logic [15:0]          draw_color;
  } in_t;

  typedef struct packed {
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  glyph;
    logic [15:0] pixel_color;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [7:0]  digit_width;
    logic [7:0]  digit_height;
    logic [7:0]  digit_spacing;
    logic [7:0]  glyph_offset;
    logic [15:0] erase_color;
  } cfg_t;

endpackage

// ===== design/ddr_planner.sv =====
// ddr_planner: decimal split of the value and the list of erase and draw commands
`timescale 1ns / 1ps

module ddr_planner import ddr_pkg::*; (
  input  in_t         item_i,
  input  count_t      shown_count_i,
  input  digit_list_t shown_digits_i,
  output plan_t       plan_o
);

  localparam int unsigned ExtBits = (ValueBits > SatBits) ? ValueBits : SatBits;

  logic [ExtBits-1:0]   value_ext;
  logic [SatBits-1:0]   value_sat;
  logic [SatBits+7:0]   tens_prod;
  logic [SatBits+5:0]   hund_prod;
  logic [6:0]           tens;
  digit_t               d0, d1, d2;
  count_t               new_count;
  digit_list_t          new_digits;
  cmd_idx_t             pos;

  function automatic cmd_t make_cmd(input logic erase, input count_t slot,
                                    input count_t n, input digit_t digit);
    cmd_t c;
    c.erase = erase;
    c.slot  = slot;
    c.n     = n;
    c.digit = digit;
    return c;
  endfunction

  // saturate, then split by reciprocal multiplication
  assign value_ext = ExtBits'(item_i.value);
  assign value_sat = (value_ext > ExtBits'(SatMax)) ? SatMax : SatBits'(value_ext);
  assign tens_prod = (SatBits+8)'(value_sat) * (SatBits+8)'(RecipTen);
  assign hund_prod = (SatBits+6)'(value_sat) * (SatBits+6)'(RecipHund);
  assign tens      = 7'(tens_prod >> RecipTenShift);
  assign d2        = 4'(hund_prod >> RecipHundShift);
  assign d1        = 4'(tens - 7'(7'(d2) * 7'(Radix)));
  assign d0        = 4'(value_sat - SatBits'(SatBits'(tens) * SatBits'(Radix)));

  assign new_digits = {d2, d1, d0};
  assign new_count  = (value_sat >= SatBits'(Radix * Radix)) ? 2'd3 :
                      (value_sat >= SatBits'(Radix))         ? 2'd2 : 2'd1;

  always_comb begin
    plan_o.cmds   = '0;
    plan_o.count  = new_count;
    plan_o.digits = new_digits;
    pos           = '0;
    if (item_i.mode == ModeHide) begin
      plan_o.count  = '0;
      plan_o.digits = shown_digits_i;
      for (int i = 0; i < NumSlots; i++) begin
        if (2'(i) < shown_count_i) begin
          plan_o.cmds[pos] = make_cmd(1'b1, 2'(i), shown_count_i, shown_digits_i[2'(i)]);
          pos = cmd_idx_t'(pos + 1'b1);
        end
      end
    end else if (new_count != shown_count_i) begin
      // count changed: erase the old group, then draw the new one
      for (int i = 0; i < NumSlots; i++) begin
        if (2'(i) < shown_count_i) begin
          plan_o.cmds[pos] = make_cmd(1'b1, 2'(i), shown_count_i, shown_digits_i[2'(i)]);
          pos = cmd_idx_t'(pos + 1'b1);
        end
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (2'(i) < new_count) begin
          plan_o.cmds[pos] = make_cmd(1'b0, 2'(i), new_count, new_digits[2'(i)]);
          pos = cmd_idx_t'(pos + 1'b1);
        end
      end
    end else begin
      // same count: touch only the digits that differ
      for (int i = 0; i < NumSlots; i++) begin
        if ((2'(i) < new_count) && (shown_digits_i[2'(i)] != new_digits[2'(i)])) begin
          plan_o.cmds[pos] = make_cmd(1'b1, 2'(i), new_count, shown_digits_i[2'(i)]);
          pos = cmd_idx_t'(pos + 1'b1);
          plan_o.cmds[pos] = make_cmd(1'b0, 2'(i), new_count, new_digits[2'(i)]);
          pos = cmd_idx_t'(pos + 1'b1);
        end
      end
    end
    plan_o.cnt = pos;
  end

endmodule

// ===== design/ddr_glyph_pos.sv =====
// ddr_glyph_pos: screen position, glyph index and color of one erase or draw command
`timescale 1ns / 1ps

module ddr_glyph_pos import ddr_pkg::*; (
  input  cmd_t        cmd_i,
  input  cfg_t        cfg_i,
  input  logic [15:0] draw_color_i,
  input  logic        last_i,
  output out_t        cmd_o
);

  logic [7:0] pitch;
  logic [7:0] n_width;
  logic [7:0] n_gaps;
  logic [7:0] total;
  logic [7:0] step_off;
  count_t     steps;

  assign pitch = 8'(cfg_i.digit_width + cfg_i.digit_spacing);
  assign steps = count_t'(cmd_i.n - 2'd1 - cmd_i.slot);

  always_comb begin
    case (cmd_i.n)
      2'd1:    n_width = cfg_i.digit_width;
      2'd2:    n_width = 8'(cfg_i.digit_width << 1);
      2'd3:    n_width = 8'(cfg_i.digit_width + 8'(cfg_i.digit_width << 1));
      default: n_width = '0;
    endcase
    case (cmd_i.n)
      2'd2:    n_gaps = cfg_i.digit_spacing;
      2'd3:    n_gaps = 8'(cfg_i.digit_spacing << 1);
      default: n_gaps = '0;
    endcase
    case (steps)
      2'd1:    step_off = pitch;
      2'd2:    step_off = 8'(pitch << 1);
      default: step_off = '0;
    endcase
  end

  assign total = 8'(n_width + n_gaps);

  assign cmd_o.x_pos       = 8'(cfg_i.center_x - (total >> 1) + step_off);
  assign cmd_o.y_pos       = 8'(cfg_i.center_y + (cfg_i.digit_height >> 1));
  assign cmd_o.glyph       = 8'(8'(cmd_i.digit) + cfg_i.glyph_offset);
  assign cmd_o.pixel_color = cmd_i.erase ? cfg_i.erase_color : draw_color_i;
  assign cmd_o.last        = last_i;

endmodule

// ===== design/decimal_digit_redraw.sv =====
// decimal_digit_redraw: top level, input register, command plan register and output register
`timescale 1ns / 1ps
// a transaction moves through the input register, the plan register and the output register
// throughput: one command per cycle unless out_ready_i stalls; a transaction with k commands
//   (0 to 6) holds the plan register until its last command leaves, the next without a gap
// the plan register, emptied one command a cycle by the output register, sets the rate
// reset (rst_ni low, asynchronous): all stages empty, nothing shown, registers at defaults

module decimal_digit_redraw import ddr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_t                    in_data_i,
  // command channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_t                   out_data_o
);

  // configuration registers
  cfg_t cfg_d, cfg_q;

  // input register
  logic in_valid_d, in_valid_q;
  in_t  in_q;

  // digits currently on screen
  count_t      shown_count_d, shown_count_q;
  digit_list_t shown_digits_q;

  // command plan register
  logic        plan_valid_d, plan_valid_q;
  cmd_idx_t    plan_idx_d, plan_idx_q;
  cmd_idx_t    plan_cnt_q;
  cmd_list_t   plan_cmds_q;
  logic [15:0] plan_color_q;

  // output register
  logic out_valid_d, out_valid_q;
  out_t out_q;

  plan_t plan;
  out_t  cmd_out;
  logic  plan_load;
  logic  plan_free;
  logic  out_load;
  logic  cmd_last;

  // ------------------------------------------------------------------
  // configuration writes; unknown indexes are dropped
  // ------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCenterX:      cfg_d.center_x      = cfg_wdata_i[7:0];
        RegCenterY:      cfg_d.center_y      = cfg_wdata_i[7:0];
        RegDigitWidth:   cfg_d.digit_width   = cfg_wdata_i[7:0];
        RegDigitHeight:  cfg_d.digit_height  = cfg_wdata_i[7:0];
        RegDigitSpacing: cfg_d.digit_spacing = cfg_wdata_i[7:0];
        RegGlyphOffset:  cfg_d.glyph_offset  = cfg_wdata_i[7:0];
        RegEraseColor:   cfg_d.erase_color   = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x      <= 8'd0;
      cfg_q.center_y      <= 8'd0;
      cfg_q.digit_width   <= 8'd1;
      cfg_q.digit_height  <= 8'd1;
      cfg_q.digit_spacing <= 8'd0;
      cfg_q.glyph_offset  <= 8'd0;
      cfg_q.erase_color   <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ------------------------------------------------------------------
  // handshake between the stages
  // ------------------------------------------------------------------
  // output register takes a command when empty or being drained
  assign out_load  = plan_valid_q && (!out_valid_q || out_ready_i);
  assign cmd_last  = (plan_idx_q == cmd_idx_t'(plan_cnt_q - 1'b1));
  // plan register is free when empty or its final command leaves this cycle
  assign plan_free = !plan_valid_q || (out_load && cmd_last);
  assign plan_load = in_valid_q && plan_free;
  // input register frees up as soon as its transaction moves into the plan
  assign in_ready_o = !in_valid_q || plan_free;

  // ------------------------------------------------------------------
  // planning: digit split and command list from the shown digits
  // ------------------------------------------------------------------
  ddr_planner u_planner (
    .item_i         (in_q),
    .shown_count_i  (shown_count_q),
    .shown_digits_i (shown_digits_q),
    .plan_o         (plan)
  );

  // ------------------------------------------------------------------
  // command geometry for the plan entry at the read pointer
  // ------------------------------------------------------------------
  ddr_glyph_pos u_glyph_pos (
    .cmd_i        (plan_cmds_q[plan_idx_q]),
    .cfg_i        (cfg_q),
    .draw_color_i (plan_color_q),
    .last_i       (cmd_last),
    .cmd_o        (cmd_out)
  );

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    in_valid_d    = in_valid_q;
    shown_count_d = shown_count_q;
    plan_valid_d  = plan_valid_q;
    plan_idx_d    = plan_idx_q;
    out_valid_d   = out_valid_q;

    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (plan_load) begin
      in_valid_d = 1'b0;
    end

    if (plan_load) begin
      // a transaction with no commands just updates the shown state
      shown_count_d = plan.count;
      plan_valid_d  = (plan.cnt != '0);
      plan_idx_d    = '0;
    end else if (out_load) begin
      if (cmd_last) begin
        plan_valid_d = 1'b0;
      end else begin
        plan_idx_d = cmd_idx_t'(plan_idx_q + 1'b1);
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      shown_count_q <= '0;
      plan_valid_q  <= 1'b0;
      plan_idx_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      in_valid_q    <= in_valid_d;
      shown_count_q <= shown_count_d;
      plan_valid_q  <= plan_valid_d;
      plan_idx_q    <= plan_idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (plan_load) begin
      shown_digits_q <= plan.digits;
      plan_cmds_q    <= plan.cmds;
      plan_cnt_q     <= plan.cnt;
      plan_color_q   <= in_q.draw_color;
    end
    if (out_load) begin
      out_q <= cmd_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // read pointer stays inside a non-empty plan
  a_plan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_valid_q |-> ((plan_cnt_q != '0) && (plan_idx_q < plan_cnt_q)))
    else $error("plan pointer outside the command list");

  // hide clears the shown count
  a_hide_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plan_load && (in_q.mode == ModeHide)) |=> (shown_count_q == '0))
    else $error("shown count not cleared by hide");

  // an update always leaves at least one digit shown
  a_update_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plan_load && (in_q.mode == ModeUpdate)) |=> (shown_count_q != '0))
    else $error("update left no digit shown");

  // a finished plan always ends on a command marked last
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cmd_last) |=> (out_valid_q && out_q.last))
    else $error("final command of a transaction not marked last");
`endif

endmodule
